FILE: rtl/lttac_pkg.sv
// lttac_pkg: shared types, constants and helpers for the lost-tick time accumulator
// used by the front, queue, back and top-level modules; no dependencies
`default_nettype none

package lttac_pkg;

  localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
  localparam logic [19:0] MICROS_MAX     = 20'd999999;
  localparam logic [19:0] TICK_LEN_RESET = 20'd10000;
  localparam logic [9:0]  MAX_GAP        = 10'd1000;

  // config register index
  localparam logic [0:0]  REG_TICK_LEN   = 1'b0;

  // front-to-back queue depth
  localparam int          QUEUE_DEPTH    = 2;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  // one classified item as handed from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic [9:0]  skip;
    logic        flag;
    logic [31:0] lost;
    logic [31:0] seconds;
    logic [19:0] micros;
  } item_t;

  function automatic logic [19:0] clamp_micros(input logic [19:0] v);
    logic [19:0] r;
    r = (v > MICROS_MAX) ? MICROS_MAX : v;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lttac_front.sv
// lttac_front: accepts items, works out skipped ticks and the lost-tick total
// depends on lttac_pkg; feeds lttac_queue
`default_nettype none

module lttac_front import lttac_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_tick_count,
  input  wire logic [31:0] in_load_seconds,
  input  wire logic [19:0] in_load_micros,
  input  wire logic        q_full,
  output logic             q_push,
  output item_t            q_item
);

  // wide enough for both the count and the plausibility limit
  localparam int GW = (COUNT_WIDTH > 11) ? COUNT_WIDTH : 11;

  logic [COUNT_WIDTH-1:0] prev_r, prev_nxt;
  logic                   first_r, first_nxt;
  logic [31:0]            lost_r, lost_nxt;

  logic [COUNT_WIDTH-1:0] reading;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] gap;
  logic [GW-1:0]          gap_ext;
  logic                   flag;
  logic [9:0]             skip;
  kind_t                  kind;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign kind     = kind_t'(in_kind);

  always_comb begin
    reading = COUNT_WIDTH'(in_tick_count);
    // first reading behaves as if the previous count was one below it
    base    = first_r ? (reading - COUNT_WIDTH'(1)) : prev_r;
    gap     = (reading == base) ? '0 : (reading - base - COUNT_WIDTH'(1));
    gap_ext = GW'(gap);
    flag    = (gap_ext > GW'(MAX_GAP));
    skip    = flag ? 10'd0 : 10'(gap_ext);
  end

  always_comb begin
    prev_nxt  = prev_r;
    first_nxt = first_r;
    lost_nxt  = lost_r;
    if (q_push && kind == KIND_TICK) begin
      prev_nxt  = reading;
      first_nxt = 1'b0;
      lost_nxt  = lost_r + 32'(skip);
    end
  end

  always_comb begin
    q_item.kind    = kind;
    q_item.seconds = in_load_seconds;
    q_item.micros  = clamp_micros(in_load_micros);
    if (kind == KIND_LOAD) begin
      q_item.skip = 10'd0;
      q_item.flag = 1'b0;
      q_item.lost = lost_r;
    end else begin
      q_item.skip = skip;
      q_item.flag = flag;
      q_item.lost = lost_r + 32'(skip);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      first_r <= 1'b1;
      lost_r  <= '0;
    end else begin
      prev_r  <= prev_nxt;
      first_r <= first_nxt;
      lost_r  <= lost_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lttac_queue.sv
// lttac_queue: short register queue between the front and the back
// depends on lttac_pkg for the item type and depth
`default_nettype none

module lttac_queue import lttac_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       nonempty,
  output item_t      head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/lttac_back.sv
// lttac_back: applies queued items to the seconds/microseconds clock,
// one tick-length bump per cycle, and holds the result register; uses lttac_pkg
`default_nettype none

module lttac_back import lttac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [19:0] step_us,
  input  wire logic        q_nonempty,
  input  wire item_t       q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_clock_seconds,
  output logic [19:0]      out_clock_micros,
  output logic [9:0]       out_skipped,
  output logic [31:0]      out_lost_total,
  output logic             out_implausible
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state_r, state_nxt;
  item_t       cur_r, cur_nxt;
  logic [9:0]  cnt_r, cnt_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [19:0] us_r, us_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] osec_r, osec_nxt;
  logic [19:0] ous_r, ous_nxt;
  logic [9:0]  oskip_r, oskip_nxt;
  logic [31:0] olost_r, olost_nxt;
  logic        oflag_r, oflag_nxt;

  logic [20:0] us_sum;
  logic        out_free;

  assign out_free = !ov_r || !out_stall;
  assign us_sum   = {1'b0, us_r} + {1'b0, step_us};

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    sec_nxt   = sec_r;
    us_nxt    = us_r;
    ov_nxt    = ov_r && out_stall;
    osec_nxt  = osec_r;
    ous_nxt   = ous_r;
    oskip_nxt = oskip_r;
    olost_nxt = olost_r;
    oflag_nxt = oflag_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_nonempty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          cnt_nxt   = q_head.skip;
          state_nxt = ST_RUN;
          if (q_head.kind == KIND_LOAD) begin
            sec_nxt = q_head.seconds;
            us_nxt  = q_head.micros;
          end
        end
      end
      ST_RUN: begin
        if (cnt_r != 10'd0) begin
          cnt_nxt = cnt_r - 10'd1;
          if (us_sum >= {1'b0, MICROS_PER_SEC}) begin
            us_nxt  = 20'(us_sum - {1'b0, MICROS_PER_SEC});
            sec_nxt = sec_r + 32'd1;
          end else begin
            us_nxt  = us_sum[19:0];
          end
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          osec_nxt  = sec_r;
          ous_nxt   = us_r;
          oskip_nxt = cur_r.skip;
          olost_nxt = cur_r.lost;
          oflag_nxt = cur_r.flag;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sec_r   <= '0;
      us_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sec_r   <= sec_nxt;
      us_r    <= us_nxt;
      ov_r    <= ov_nxt;
    end
    cur_r   <= cur_nxt;
    osec_r  <= osec_nxt;
    ous_r   <= ous_nxt;
    oskip_r <= oskip_nxt;
    olost_r <= olost_nxt;
    oflag_r <= oflag_nxt;
  end

  assign out_valid         = ov_r;
  assign out_clock_seconds = osec_r;
  assign out_clock_micros  = ous_r;
  assign out_skipped       = oskip_r;
  assign out_lost_total    = olost_r;
  assign out_implausible   = oflag_r;

  a_micros_range: assert property (@(posedge clk) disable iff (!rst_n)
    us_r < MICROS_PER_SEC)
    else $error("clock micros out of range");

  a_result_after_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == ST_RUN && cnt_r == 10'd0))
    else $error("result issued before bumps finished");

  a_load_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == KIND_LOAD) |-> (q_head.skip == 10'd0 && !q_head.flag))
    else $error("load item carries skipped ticks");

endmodule

`default_nettype wire

FILE: rtl/lost_tick_time_accumulator_top.sv
// lost_tick_time_accumulator_top: top level of the lost-tick time accumulator
// depends on lttac_pkg, lttac_front, lttac_queue and lttac_back
//
// usage:
//  - input channel (in_valid / in_stall): one item per interrupt; in_kind selects
//    a tick count reading or a clock load (load_seconds, load_micros)
//  - result channel (out_valid / out_stall): exactly one item back per input item,
//    in order, carrying the clock, the skipped ticks, the lost total and the flag
//  - cfg_* port: apb-style, one register, tick_length_us at byte address 0;
//    values above 999999 act as 999999, write it only while the block is idle
//  - the front classifies each reading at the accept edge (gap, plausibility,
//    lost total) and pushes it into a two-entry queue; in_stall is queue full
//  - the back applies one tick-length bump per cycle, one per skipped tick,
//    skipped being 0..1000 (0 for loads and flagged gaps), then writes the
//    result register; it takes no new item until the current one is written out
//  - the result sits in an output register; while out_stall is high it holds,
//    the back finishes the next item and waits, and the queue keeps filling
//  - reset (rst_n low, synchronous) clears the clock, lost total and queue,
//    arms the first-reading case and sets tick_length_us to 10000
`default_nettype none

module lost_tick_time_accumulator_top import lttac_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_tick_count,
  input  wire logic [31:0] in_load_seconds,
  input  wire logic [19:0] in_load_micros,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_clock_seconds,
  output logic [19:0]      out_clock_micros,
  output logic [9:0]       out_skipped,
  output logic [31:0]      out_lost_total,
  output logic             out_implausible,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // tick length register, raw 20 bits as written
  logic [19:0] tick_len_r, tick_len_nxt;
  logic        cfg_wr;
  logic [0:0]  cfg_index;
  logic [19:0] step_us;

  // front/queue/back hookup
  logic  q_push, q_full, q_pop, q_nonempty;
  item_t q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    tick_len_nxt = tick_len_r;
    if (cfg_wr && cfg_index == REG_TICK_LEN) begin
      tick_len_nxt = cfg_pwdata[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_len_r <= TICK_LEN_RESET;
    end else begin
      tick_len_r <= tick_len_nxt;
    end
  end

  // reads of anything but the tick length return zero
  assign cfg_prdata = (cfg_index == REG_TICK_LEN) ? 32'(tick_len_r) : 32'd0;

  // oversized tick lengths saturate at one second minus a microsecond
  assign step_us = clamp_micros(tick_len_r);

  lttac_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_tick_count   (in_tick_count),
    .in_load_seconds (in_load_seconds),
    .in_load_micros  (in_load_micros),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_in)
  );

  lttac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  lttac_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_us           (step_us),
    .q_nonempty        (q_nonempty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_clock_seconds (out_clock_seconds),
    .out_clock_micros  (out_clock_micros),
    .out_skipped       (out_skipped),
    .out_lost_total    (out_lost_total),
    .out_implausible   (out_implausible)
  );

endmodule

`default_nettype wire

FILE: test/tb_lost_tick_time_accumulator_top.sv
// tb_lost_tick_time_accumulator_top: self-checking bench for the lost-tick time accumulator
// drives tick readings and clock loads, predicts every result and checks it in order
// depends on lttac_pkg and lost_tick_time_accumulator_top
`timescale 1ns / 1ps

module tb_lost_tick_time_accumulator_top;
  import lttac_pkg::*;

  // byte addresses on the config port, one register per 4 bytes
  localparam logic [2:0] CFG_ADDR_TICK_LEN = {REG_TICK_LEN, 2'b00};
  // index 1 has no register behind it, a write there must change nothing
  localparam logic [2:0] CFG_ADDR_UNUSED   = 3'd4;

  // longest correct quiet stretch: a 1000-tick reading sitting behind a receiver
  // hold and a random stall; taken several times over
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES    = 200;
  // settle time after the last result, a bit above the worst item latency
  localparam int DRAIN_CYCLES   = 1100;

  // one item on the input channel
  typedef struct {
    kind_t       kind;
    logic [31:0] count;
    logic [31:0] secs;
    logic [19:0] usec;
  } irq_item_t;

  // one expected item on the result channel
  typedef struct {
    logic [31:0] secs;
    logic [19:0] usec;
    logic [9:0]  skip;
    logic [31:0] lost;
    logic        flag;
  } clock_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [31:0] in_tick_count = '0;
  logic [31:0] in_load_seconds = '0;
  logic [19:0] in_load_micros = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_clock_seconds;
  logic [19:0] out_clock_micros;
  logic [9:0]  out_skipped;
  logic [31:0] out_lost_total;
  logic        out_implausible;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lost_tick_time_accumulator_top #(
    .COUNT_WIDTH(32)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_tick_count    (in_tick_count),
    .in_load_seconds  (in_load_seconds),
    .in_load_micros   (in_load_micros),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clock_seconds(out_clock_seconds),
    .out_clock_micros (out_clock_micros),
    .out_skipped      (out_skipped),
    .out_lost_total   (out_lost_total),
    .out_implausible  (out_implausible),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // items waiting for the driver, results waiting for the block
  irq_item_t    irq_q[$];
  clock_state_t clock_expect_q[$];
  irq_item_t    cur_item;

  // mirror of the block's clock, lost-tick and last-count state
  logic [19:0] tick_len = TICK_LEN_RESET;
  logic [31:0] pred_prev;
  logic        pred_first;
  logic [31:0] pred_lost;
  logic [31:0] pred_secs;
  logic [19:0] pred_usec;

  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned offered_count = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int          gap_left = 0;
  logic [2:0]  stall_left = '0;
  int          hold_left = 0;
  int unsigned next_hold_at = 80;
  logic [31:0] gen_count = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one accepted item to the mirror state and return what the block must report
  function automatic clock_state_t advance_clock(input irq_item_t it);
    clock_state_t r;
    logic [31:0]  gap;
    logic [63:0]  step;
    logic [63:0]  usec_sum;
    gap = '0;
    r.flag = 1'b0;
    if (it.kind == KIND_LOAD) begin
      pred_secs = it.secs;
      pred_usec = (it.usec > MICROS_MAX) ? MICROS_MAX : it.usec;
    end else begin
      step = 64'((tick_len > MICROS_MAX) ? MICROS_MAX : tick_len);
      // first reading after reset: pretend the previous count was one below
      if (pred_first) begin
        pred_prev = it.count - 32'd1;
        pred_first = 1'b0;
      end
      // a repeated count skips nothing, anything else is gap minus one, mod 2^32
      if (it.count != pred_prev)
        gap = it.count - pred_prev - 32'd1;
      if (gap > 32'(MAX_GAP)) begin
        r.flag = 1'b1;
        gap = '0;
      end
      pred_lost = pred_lost + gap;
      // each skipped tick adds at most one carry, so the sum can be split at once
      usec_sum = 64'(pred_usec);
      usec_sum = usec_sum + 64'(gap) * step;
      pred_secs = pred_secs + 32'(usec_sum / 64'(MICROS_PER_SEC));
      pred_usec = 20'(usec_sum % 64'(MICROS_PER_SEC));
      pred_prev = it.count;
    end
    r.secs = pred_secs;
    r.usec = pred_usec;
    r.skip = gap[9:0];
    r.lost = pred_lost;
    return r;
  endfunction

  task automatic push_tick(input logic [31:0] count);
    irq_item_t it;
    it.kind = KIND_TICK;
    it.count = count;
    it.secs = $urandom;
    it.usec = 20'($urandom);
    irq_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_load(input logic [31:0] secs, input logic [19:0] usec);
    irq_item_t it;
    it.kind = KIND_LOAD;
    it.count = $urandom;
    it.secs = secs;
    it.usec = usec;
    irq_q.push_back(it);
    items_queued++;
  endtask

  // mostly well-formed count streams, with loads, repeats, wraps and bad jumps mixed in
  task automatic queue_random(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99, 0);
      if (r < 10) begin
        push_load($urandom, (r < 2) ? 20'($urandom) : 20'($urandom_range(999999, 0)));
      end else begin
        if (r < 13)
          gen_count = $urandom;                                  // wild jump
        else if (r < 15)
          gen_count = 32'hFFFF_FFFF - $urandom_range(6, 0);      // park near the wrap
        else if (r < 18)
          gen_count = gen_count;                                 // repeated count
        else if (r < 22)
          gen_count = gen_count + $urandom_range(1002, 5);       // long gap, near the limit
        else if (r < 24)
          gen_count = gen_count - $urandom_range(3, 1);          // count went backwards
        else if (r < 60)
          gen_count = gen_count + 32'd1;                         // on time
        else
          gen_count = gen_count + 32'd1 + $urandom_range(3, 0);  // a few lost ticks
        push_tick(gen_count);
      end
    end
  endtask

  // idle means every queued item has come back as a result
  task automatic wait_idle();
    while (results_seen != items_queued)
      @(posedge clk);
  endtask

  // setup cycle, then access cycle held until pready
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr[2] == REG_TICK_LEN)
      tick_len = data[19:0];
  endtask

  // driver: one item on the bus at a time, random gap after each accept outside back-to-back stretches
  always @(posedge clk) begin : driver
    irq_item_t    it;
    clock_state_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      pred_prev = '0;
      pred_first = 1'b1;
      pred_lost = '0;
      pred_secs = '0;
      pred_usec = '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        want = advance_clock(cur_item);
        clock_expect_q.push_back(want);
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (irq_q.size() != 0) begin
        it = irq_q.pop_front();
        cur_item <= it;
        in_kind <= it.kind;
        in_tick_count <= it.count;
        in_load_seconds <= it.secs;
        in_load_micros <= it.usec;
        in_valid <= 1'b1;
        offered_count <= offered_count + 1;
        // every third stretch of 50 items goes back to back
        gap_left <= ((offered_count / 50) % 3 == 0) ? 0 : $urandom_range(4, 0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold while the sender is still offering, so the queue fills
  always @(posedge clk) begin : receiver_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at && in_valid) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 250;
    end
  end

  // monitor: compare each result with the oldest expectation, then draw a stall
  always @(posedge clk) begin : monitor
    clock_state_t want;
    logic [2:0]   w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= '0;
    end else begin
      w = stall_left;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (clock_expect_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result secs=%0d usec=%0d skip=%0d lost=%0d flag=%0b",
                     $time, out_clock_seconds, out_clock_micros, out_skipped,
                     out_lost_total, out_implausible);
          errors++;
        end else begin
          want = clock_expect_q.pop_front();
          if (out_clock_seconds !== want.secs || out_clock_micros !== want.usec ||
              out_skipped !== want.skip || out_lost_total !== want.lost ||
              out_implausible !== want.flag) begin
            if (errors < 10) begin
              $display("%0t: result %0d mismatch", $time, results_seen);
              $display("  expected secs=%0d usec=%0d skip=%0d lost=%0d flag=%0b",
                       want.secs, want.usec, want.skip, want.lost, want.flag);
              $display("  actual   secs=%0d usec=%0d skip=%0d lost=%0d flag=%0b",
                       out_clock_seconds, out_clock_micros, out_skipped,
                       out_lost_total, out_implausible);
            end
            errors++;
          end
        end
        // one stretch in three takes results with no random stall (receiver holds still apply)
        w = ((results_seen / 40) % 3 == 1) ? 3'd0 : 3'($urandom_range(4, 0));
      end else if (w != 0) begin
        w = w - 3'd1;
      end
      stall_left <= w;
      out_stall <= (w != 0) || (hold_left != 0);
    end
  end

  // watchdog on cycles where no handshake completes anywhere
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at the reset tick length of 10 ms
    push_load(32'h0000_0010, 20'd5);          // load before any reading keeps first-reading state
    push_tick(32'd100);                       // first reading skips nothing
    push_tick(32'd101);
    push_tick(32'd103);                       // one lost tick
    push_tick(32'd103);                       // repeated count, not flagged
    push_tick(32'd1104);                      // largest plausible gap
    push_tick(32'd2106);                      // one past the limit
    push_tick(32'd2105);                      // count went backwards
    push_tick(32'hFFFF_FFFE);
    push_tick(32'hFFFF_FFFF);
    push_tick(32'h0000_0001);                 // wraps through zero with one lost tick
    push_load(32'hFFFF_FFFF, 20'd999999);
    push_tick(32'd3);                         // micros carry wraps the seconds
    push_load(32'h0000_0000, 20'hFFFFF);      // oversized micros saturate
    push_load(32'hAAAA_AAAA, 20'h00000);
    push_load(32'h5555_5555, 20'h55555);
    push_tick(32'h0000_0000);
    push_tick(32'd500);
    push_tick(32'hAAAA_AAAA);
    push_tick(32'h5555_5555);
    gen_count = 32'h5555_5555;
    wait_idle();

    // random phases, each under its own tick length
    cfg_write(CFG_ADDR_TICK_LEN, 32'h000F_FFFF);          // oversized, acts as the max
    queue_random(100);
    wait_idle();
    cfg_write(CFG_ADDR_TICK_LEN, 32'd1);
    queue_random(100);
    wait_idle();
    cfg_write(CFG_ADDR_UNUSED, 32'd777);                  // no register there
    queue_random(60);
    wait_idle();
    cfg_write(CFG_ADDR_TICK_LEN, 32'd0);                  // clock stands still
    queue_random(80);
    wait_idle();
    cfg_write(CFG_ADDR_TICK_LEN, {12'hABC, 20'd250000});  // upper data bits dropped
    queue_random(100);
    wait_idle();
    cfg_write(CFG_ADDR_TICK_LEN, 32'd999999);
    queue_random(80);
    wait_idle();
    cfg_write(CFG_ADDR_TICK_LEN, 32'($urandom_range(999999, 1)));
    queue_random(80);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (clock_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, clock_expect_q.size());
      errors++;
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
